### rtl/mma_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiply-accumulate block.
`default_nettype none

package mma_pkg;

    // Default matrix dimension and fraction bits of the Q format
    localparam int DIM_DEF       = 4;
    localparam int FRAC_BITS_DEF = 16;

    // Width of one matrix element
    localparam int VAL_W = 32;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One completed operand matrix handed to the back
    typedef struct packed {
        logic restart;
    } mma_job_t;

    // Queue fill status seen by the front
    typedef struct packed {
        logic empty;
        logic full;
    } mma_queue_status_t;

    // Back status seen by the front
    typedef struct packed {
        logic opnd_busy;
    } mma_back_status_t;

endpackage

`default_nettype wire

### rtl/mma_front.sv
// Front end: accepts operand requests, fills the operand store and queues product jobs.
`default_nettype none

module mma_front
    import mma_pkg::*;
#(
    parameter int DIM   = DIM_DEF,
    parameter int POS_W = 4
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [POS_W-1:0]             s_position,
    input  wire  [VAL_W-1:0]             s_element_value,
    input  wire                          s_restart,
    input  mma_queue_status_t            q_status,
    output logic                         q_push,
    output mma_job_t                     q_job,
    input  mma_back_status_t             back_status,
    input  wire  [$clog2(DIM)-1:0]       rd_col,
    output logic [DIM-1:0][VAL_W-1:0]    col_data
);

    localparam int NELEM = DIM * DIM;

    // Operand store, organized by column so the back reads one column at a time
    logic [DIM-1:0][VAL_W-1:0] opnd_reg [DIM];
    logic                      pending_reg;

    logic accept;
    logic in_range;
    logic complete;

    // Hold requests while a job waits or the back still reads the operand
    assign s_ready  = q_status.empty & ~q_status.full & ~back_status.opnd_busy;
    assign accept   = s_valid & s_ready;
    assign in_range = {1'b0, s_position} < (POS_W+1)'(NELEM);
    assign complete = accept & (s_position == POS_W'(NELEM - 1));

    // Write the element into its slot
    always_ff @(posedge aclk) begin
        for (int c = 0; c < DIM; c++) begin
            for (int r = 0; r < DIM; r++) begin
                if (accept && in_range && (s_position == POS_W'(r * DIM + c))) begin
                    opnd_reg[c][r] <= s_element_value;
                end
            end
        end
    end

    // Track a restart mark until the matrix completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else if (complete) begin
            pending_reg <= 1'b0;
        end else if (accept && s_restart) begin
            pending_reg <= 1'b1;
        end
    end

    // Queue a product job on the last position
    assign q_push        = complete;
    assign q_job.restart = pending_reg | s_restart;

    // Column read for the back
    assign col_data = opnd_reg[rd_col];

endmodule

`default_nettype wire

### rtl/mma_job_queue.sv
// Short job queue that decouples the front from the back.
`default_nettype none

module mma_job_queue
    import mma_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  mma_job_t          push_job,
    input  wire               pop,
    output mma_job_t          pop_job,
    output mma_queue_status_t status
);

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mma_job_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic do_push;
    logic do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push & ~status.full;
    assign do_pop       = pop & ~status.empty;
    assign pop_job      = slot_reg[rd_ptr_reg];

    // Store a pushed job
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("job pushed into a full queue");
`endif

endmodule

`default_nettype wire

### rtl/mma_back.sv
// Back end: holds the accumulator, forms one product element per cycle unless stalled, emits results.
`default_nettype none

module mma_back
    import mma_pkg::*;
#(
    parameter int DIM       = DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int POS_W     = 4
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          job_valid,
    input  mma_job_t                     job,
    output logic                         pop,
    output mma_back_status_t             status,
    output logic [$clog2(DIM)-1:0]       rd_col,
    input  wire  [DIM-1:0][VAL_W-1:0]    col_data,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [POS_W-1:0]             m_out_position,
    output logic [VAL_W-1:0]             m_out_value,
    output logic                         m_last
);

    localparam int NELEM = DIM * DIM;
    localparam int CW    = $clog2(DIM);
    localparam int PW    = 2 * VAL_W;
    localparam int TW    = PW - FRAC_BITS;
    localparam int XB    = $clog2(DIM);
    localparam int SW    = TW + XB;
    localparam logic [VAL_W-1:0] ONE =
        {{(VAL_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic {
        ST_IDLE,
        ST_ISSUE
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             row_reg;
    logic [CW-1:0]             col_reg;
    logic [POS_W-1:0]          num_reg;
    logic [DIM-1:0][VAL_W-1:0] acc_reg [DIM];

    // Copy of the accumulator row taken on its first column
    logic [DIM-1:0][VAL_W-1:0] row_buf_reg;
    logic [DIM-1:0][VAL_W-1:0] acc_row;

    // Multiply stage
    logic                      s1_valid_reg;
    logic signed [PW-1:0]      prod_reg [DIM];
    logic [CW-1:0]             s1_row_reg;
    logic [CW-1:0]             s1_col_reg;
    logic [POS_W-1:0]          s1_num_reg;
    logic                      s1_last_reg;

    // Sum stage
    logic                      s2_valid_reg;
    logic signed [SW-1:0]      s2_sum_reg;
    logic [CW-1:0]             s2_row_reg;
    logic [CW-1:0]             s2_col_reg;
    logic [POS_W-1:0]          s2_num_reg;
    logic                      s2_last_reg;

    // Output register
    logic                      m_valid_reg;
    logic [POS_W-1:0]          m_pos_reg;
    logic [VAL_W-1:0]          m_value_reg;
    logic                      m_last_reg;

    logic                      en;
    logic                      start;
    logic                      issue;
    logic                      issue_last;
    logic signed [SW-1:0]      sum_next;
    logic [VAL_W-1:0]          sat_value;
    logic [SW-VAL_W:0]         sum_hi;

    // Freeze the whole pipeline while a result waits
    assign en         = ~m_valid_reg | m_ready;
    assign start      = (state_reg == ST_IDLE) & job_valid & ~s1_valid_reg & ~s2_valid_reg;
    assign issue      = (state_reg == ST_ISSUE) & en;
    assign issue_last = issue & (num_reg == POS_W'(NELEM - 1));
    assign pop        = start;
    assign rd_col     = col_reg;

    assign status.opnd_busy = (state_reg == ST_ISSUE);

    // Sequence the elements of one product and drive the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            num_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        num_reg   <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (en) begin
                        num_reg <= num_reg + 1'b1;
                        if (col_reg == CW'(DIM - 1)) begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end else begin
                            col_reg <= col_reg + 1'b1;
                        end
                        if (issue_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (en) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
        if (en && s2_valid_reg) begin
            m_pos_reg   <= s2_num_reg;
            m_value_reg <= sat_value;
            m_last_reg  <= s2_last_reg;
        end
    end

    // Use the live row on its first column, the held copy after that, since
    // write-back of this row starts before the row is fully issued
    assign acc_row = (col_reg == '0) ? acc_reg[row_reg] : row_buf_reg;

    // Multiply one accumulator row by one operand column, all lanes at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= issue;
        end
        if (issue) begin
            if (col_reg == '0) begin
                row_buf_reg <= acc_reg[row_reg];
            end
            for (int k = 0; k < DIM; k++) begin
                prod_reg[k] <= $signed(acc_row[k]) * $signed(col_data[k]);
            end
            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_reg;
            s1_num_reg  <= num_reg;
            s1_last_reg <= (num_reg == POS_W'(NELEM - 1));
        end
    end

    // Truncate each product and add them exactly
    always_comb begin
        logic signed [PW-1:0] term;
        sum_next = '0;
        for (int k = 0; k < DIM; k++) begin
            term     = prod_reg[k] >>> FRAC_BITS;
            sum_next = sum_next + {{XB{term[TW-1]}}, term[TW-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (en && s1_valid_reg) begin
            s2_sum_reg  <= sum_next;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_num_reg  <= s1_num_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Saturate the sum to the element range
    assign sum_hi = s2_sum_reg[SW-1:VAL_W-1];
    always_comb begin
        if ((&sum_hi) || !(|sum_hi)) begin
            sat_value = s2_sum_reg[VAL_W-1:0];
        end else if (s2_sum_reg[SW-1]) begin
            sat_value = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    // Reload identity on restart, write each product element back
    always_ff @(posedge aclk) begin
        if (!aresetn || (start && job.restart)) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    acc_reg[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else if (en && s2_valid_reg) begin
            acc_reg[s2_row_reg][s2_col_reg] <= sat_value;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_position = m_pos_reg;
    assign m_out_value    = m_value_reg;
    assign m_last         = m_last_reg;

`ifndef ASSERT_OFF
    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_pos_reg == POS_W'(NELEM - 1)))
        else $error("last mark on a result that is not the final element");

    a_issue_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_last |=> (state_reg == ST_IDLE) && s1_valid_reg && s1_last_reg)
        else $error("final element issued but sequencer did not finish");
`endif

endmodule

`default_nettype wire

### rtl/matrix4_multiply_accumulate.sv
// Top level of the fixed-point matrix multiply-accumulate block.
//
//   channel   | direction | tdata (low bit up)               | tuser   | tlast
//   ----------+-----------+----------------------------------+---------+------
//   s_ (in)   | request   | position, element_value, pad     | restart | -
//   m_ (out)  | result    | out_position, out_value, pad     | -       | last
//
// On the last position a job is queued; the back takes it from the queue once it is
// idle and its pipeline is empty, and issues one product element per cycle while
// m_tready does not stall it (DIM multipliers in parallel); each element passes the
// multiply stage and the sum stage into the output register.
// Requests are held while a job waits and while the back reads the operand store.
// Reset loads the identity into the accumulator directly; no clearing pass.
// m_tready low freezes the back pipeline; once the back has issued its last
// element, the front keeps taking requests meanwhile.
`default_nettype none

module matrix4_multiply_accumulate
    import mma_pkg::*;
#(
    parameter int DIM       = DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int POS_W     = (DIM * DIM > 16) ? $clog2(DIM * DIM) : 4,
    parameter int DATA_W    = ((POS_W + VAL_W + 7) / 8) * 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [DATA_W-1:0]   s_tdata,   // position, element_value, zero pad
    input  wire                 s_tuser,   // restart
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [DATA_W-1:0]   m_tdata,   // out_position, out_value, zero pad
    output logic                m_tlast
);

    mma_queue_status_t          q_status;
    mma_back_status_t           back_status;
    mma_job_t                   push_job;
    mma_job_t                   pop_job;
    logic                       q_push;
    logic                       q_pop;
    logic [$clog2(DIM)-1:0]     rd_col;
    logic [DIM-1:0][VAL_W-1:0]  col_data;
    logic [POS_W-1:0]           out_position;
    logic [VAL_W-1:0]           out_value;

    mma_front #(
        .DIM   (DIM),
        .POS_W (POS_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_tvalid),
        .s_ready         (s_tready),
        .s_position      (s_tdata[POS_W-1:0]),
        .s_element_value (s_tdata[POS_W+VAL_W-1:POS_W]),
        .s_restart       (s_tuser),
        .q_status        (q_status),
        .q_push          (q_push),
        .q_job           (push_job),
        .back_status     (back_status),
        .rd_col          (rd_col),
        .col_data        (col_data)
    );

    mma_job_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    mma_back #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS),
        .POS_W     (POS_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (~q_status.empty),
        .job            (pop_job),
        .pop            (q_pop),
        .status         (back_status),
        .rd_col         (rd_col),
        .col_data       (col_data),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_out_position (out_position),
        .m_out_value    (out_value),
        .m_last         (m_tlast)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {{(DATA_W-POS_W-VAL_W){1'b0}}, out_value, out_position};

`ifndef ASSERT_OFF
    a_no_write_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !back_status.opnd_busy && q_status.empty)
        else $error("operand store open to requests while a product reads it");
`endif

endmodule

`default_nettype wire
